@@ src/rpfl_pkg.sv @@
package rpfl_pkg;

    localparam int POOL_SLOTS_DEF = 256;
    localparam int SLOT_W         = 8;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_ENQUEUE = 2'd2,
        FUNC_DEQUEUE = 2'd3
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [SLOT_W-1:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_out;
        logic               found;
        logic               index_error;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic accept;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

@@ src/record_pool_free_list_queue.sv @@
// Channel | Ports                          | Carries
// --------+--------------------------------+-----------------------------------
// input   | s_valid, s_ready, s_item       | func, slot_index
// result  | m_valid, m_ready, m_item       | slot_out, found, index_error
//
// The accept cycle issues the link-memory read (pop) or first link write
// (append); the execute state completes it once the output register is free.
// The read of the next-link memory is registered, and its
// single write port splits an append into two writes.
// After reset a sweep over all POOL_SLOTS slots builds the initial free list;
// s_ready stays low during it.
// A result waits in the output register while the next transaction is
// accepted; execution holds only if that result is still untaken.
module record_pool_free_list_queue #(
    parameter int POOL_SLOTS = rpfl_pkg::POOL_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rpfl_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rpfl_pkg::out_item_t m_item
);

    rpfl_pkg::cmd_t    cmd;
    rpfl_pkg::status_t status;

    rpfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rpfl_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

@@ src/rpfl_ram.sv @@
module rpfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/rpfl_ctrl.sv @@
module rpfl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpfl_pkg::status_t status,
    output rpfl_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.clr_en = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold here while the output register still carries an unread result
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

@@ src/rpfl_dp.sv @@
module rpfl_dp #(
    parameter int POOL_SLOTS = rpfl_pkg::POOL_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rpfl_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rpfl_pkg::out_item_t m_item,
    input  rpfl_pkg::cmd_t      cmd,
    output rpfl_pkg::status_t   status
);

    localparam int ADDR_W = $clog2(POOL_SLOTS);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int CMP_W  = (PTR_W > rpfl_pkg::SLOT_W) ? PTR_W : rpfl_pkg::SLOT_W;
    localparam logic [PTR_W-1:0]  NONE      = PTR_W'(POOL_SLOTS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_SLOTS - 1);

    // Only forward links are kept: no operation ever walks a list backward.
    logic [PTR_W-1:0]  free_head_reg, free_head_next;
    logic [PTR_W-1:0]  free_tail_reg, free_tail_next;
    logic [PTR_W-1:0]  act_head_reg, act_head_next;
    logic [PTR_W-1:0]  act_tail_reg, act_tail_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    rpfl_pkg::func_t     op_reg;
    logic [PTR_W-1:0]    idx_reg;
    logic                idx_ok_reg;
    logic                m_valid_reg, m_valid_next;
    rpfl_pkg::out_item_t m_item_reg, m_item_next;

    logic              idx_ok;
    logic              in_push;
    logic [PTR_W-1:0]  in_head;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PTR_W-1:0]  wr_data;
    logic [PTR_W-1:0]  rd_data;
    logic              op_pop, op_free;
    logic [PTR_W-1:0]  cur_head, cur_tail;
    logic              head_ok, tail_ok, next_ok;

    assign idx_ok  = CMP_W'(s_item.slot_index) < CMP_W'(POOL_SLOTS);
    assign in_push = (s_item.func == rpfl_pkg::FUNC_RELEASE) ||
                     (s_item.func == rpfl_pkg::FUNC_ENQUEUE);
    assign in_head = (s_item.func == rpfl_pkg::FUNC_ALLOC) ? free_head_reg : act_head_reg;

    assign op_pop   = (op_reg == rpfl_pkg::FUNC_ALLOC) || (op_reg == rpfl_pkg::FUNC_DEQUEUE);
    assign op_free  = (op_reg == rpfl_pkg::FUNC_ALLOC) || (op_reg == rpfl_pkg::FUNC_RELEASE);
    assign cur_head = op_free ? free_head_reg : act_head_reg;
    assign cur_tail = op_free ? free_tail_reg : act_tail_reg;
    assign head_ok  = cur_head < NONE;
    assign tail_ok  = cur_tail < NONE;
    assign next_ok  = rd_data < NONE;

    // single write port: init sweep, terminate appended slot at accept,
    // link old tail to it on finish
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = NONE;
        if (cmd.clr_en) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = PTR_W'({1'b0, clr_cnt_reg}) + PTR_W'(1);
        end else if (cmd.accept && in_push && idx_ok) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(s_item.slot_index);
            wr_data = NONE;
        end else if (cmd.finish && !op_pop && idx_ok_reg && tail_ok) begin
            wr_en   = 1'b1;
            wr_addr = cur_tail[ADDR_W-1:0];
            wr_data = idx_reg;
        end
    end

    rpfl_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_SLOTS)
    ) u_next_link (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (in_head[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        free_head_next = free_head_reg;
        free_tail_next = free_tail_reg;
        act_head_next  = act_head_reg;
        act_tail_next  = act_tail_reg;
        clr_cnt_next   = cmd.clr_en ? clr_cnt_reg + ADDR_W'(1) : clr_cnt_reg;
        m_item_next    = m_item_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (cmd.finish) begin
            m_valid_next = 1'b1;
            m_item_next  = '0;
            if (op_pop) begin
                if (head_ok) begin
                    m_item_next.slot_out = rpfl_pkg::SLOT_W'(cur_head);
                    m_item_next.found    = 1'b1;
                    if (op_free) begin
                        free_head_next = next_ok ? rd_data : NONE;
                        free_tail_next = next_ok ? free_tail_reg : NONE;
                    end else begin
                        act_head_next = next_ok ? rd_data : NONE;
                        act_tail_next = next_ok ? act_tail_reg : NONE;
                    end
                end
            end else if (!idx_ok_reg) begin
                m_item_next.index_error = 1'b1;
            end else if (op_free) begin
                free_tail_next = idx_reg;
                if (!tail_ok) begin
                    free_head_next = idx_reg;
                end
            end else begin
                act_tail_next = idx_reg;
                if (!tail_ok) begin
                    act_head_next = idx_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            free_tail_reg <= PTR_W'(POOL_SLOTS - 1);
            act_head_reg  <= NONE;
            act_tail_reg  <= NONE;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            free_head_reg <= free_head_next;
            free_tail_reg <= free_tail_next;
            act_head_reg  <= act_head_next;
            act_tail_reg  <= act_tail_next;
            clr_cnt_reg   <= clr_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        if (cmd.accept) begin
            op_reg     <= s_item.func;
            idx_reg    <= PTR_W'(s_item.slot_index);
            idx_ok_reg <= idx_ok;
        end
    end

    assign status.clr_last = (clr_cnt_reg == LAST_ADDR);
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_item          = m_item_reg;

endmodule

@@ src/rpfl_chk.sv @@
module rpfl_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rpfl_pkg::out_item_t m_item
);

    // one transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after an accept");

    // a new result only appears out of the execute cycle
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without execution");

    a_found_vs_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.found && m_item.index_error))
        else $error("found and index_error both set");

    a_zero_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.found |-> m_item.slot_out == '0)
        else $error("slot_out nonzero without a popped slot");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

endmodule

bind record_pool_free_list_queue rpfl_chk u_rpfl_chk (.*);

@@ dv/tb_record_pool_free_list_queue.sv @@
module tb_record_pool_free_list_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import rpfl_pkg::*;

    localparam int POOL_SLOTS   = POOL_SLOTS_DEF;
    localparam int LINK_W       = $clog2(POOL_SLOTS) + 1;
    localparam int N_RANDOM     = 1050;
    localparam int LIMIT_CYCLES = 200000;

    typedef logic [LINK_W-1:0] link_t;
    localparam link_t LINK_NONE = link_t'(POOL_SLOTS);

    typedef enum {PH_ALLOC, PH_ENQ, PH_DEQ, PH_REL, PH_MIX, PH_NOISE} phase_t;

    // Mirror of the slot pool: link memories, list pointers, and the
    // results still owed by the block, oldest first.
    class pool_scoreboard;
        link_t      fwd [POOL_SLOTS];
        link_t      bwd [POOL_SLOTS];
        link_t      free_hd, free_tl, act_hd, act_tl;
        out_item_t  owed_q[$];
        int         mismatches;

        function new();
            for (int i = 0; i < POOL_SLOTS; i++) begin
                fwd[i] = (i + 1 < POOL_SLOTS) ? link_t'(i + 1) : LINK_NONE;
                bwd[i] = (i == 0) ? LINK_NONE : link_t'(i - 1);
            end
            free_hd    = '0;
            free_tl    = link_t'(POOL_SLOTS - 1);
            act_hd     = LINK_NONE;
            act_tl     = LINK_NONE;
            mismatches = 0;
        endfunction

        function bit in_pool(link_t v);
            return int'(v) < POOL_SLOTS;
        endfunction

        function void pop_head(bit act, output bit ok, output link_t s);
            link_t h;
            link_t n;
            h  = act ? act_hd : free_hd;
            ok = in_pool(h);
            s  = h;
            if (!ok)
                return;
            n = fwd[h[LINK_W-2:0]];
            if (in_pool(n)) begin
                if (act) act_hd = n; else free_hd = n;
                bwd[n[LINK_W-2:0]] = LINK_NONE;
            end else begin
                // end of list (or junk link): list goes empty
                if (act) begin
                    act_hd = LINK_NONE;
                    act_tl = LINK_NONE;
                end else begin
                    free_hd = LINK_NONE;
                    free_tl = LINK_NONE;
                end
            end
        endfunction

        // Blind append: no check that s is already on some list.
        function void push_tail(bit act, link_t s);
            link_t t;
            t                  = act ? act_tl : free_tl;
            fwd[s[LINK_W-2:0]] = LINK_NONE;
            bwd[s[LINK_W-2:0]] = in_pool(t) ? t : LINK_NONE;
            if (in_pool(t))
                fwd[t[LINK_W-2:0]] = s;
            else if (act)
                act_hd = s;
            else
                free_hd = s;
            if (act) act_tl = s; else free_tl = s;
        endfunction

        function out_item_t note_input(in_item_t it);
            out_item_t r;
            bit        ok;
            link_t     s;
            r = '0;
            case (it.func)
                FUNC_ALLOC, FUNC_DEQUEUE: begin
                    pop_head(it.func == FUNC_DEQUEUE, ok, s);
                    if (ok) begin
                        r.slot_out = s[SLOT_W-1:0];
                        r.found    = 1'b1;
                    end
                end
                default: begin
                    if (int'(it.slot_index) < POOL_SLOTS)
                        push_tail(it.func == FUNC_ENQUEUE, link_t'(it.slot_index));
                    else
                        r.index_error = 1'b1;
                end
            endcase
            owed_q.push_back(r);
            return r;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (owed_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: slot_out=%0d found=%0b index_error=%0b",
                             got.slot_out, got.found, got.index_error);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            if (got.slot_out !== want.slot_out || got.found !== want.found ||
                got.index_error !== want.index_error) begin
                if (mismatches < 10)
                    $display("mismatch: exp slot_out=%0d found=%0b index_error=%0b, %s%0d %s%0b %s%0b",
                             want.slot_out, want.found, want.index_error,
                             "got slot_out=", got.slot_out, "found=", got.found,
                             "index_error=", got.index_error);
                mismatches++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;

    pool_scoreboard sb = new();
    logic [SLOT_W-1:0] held_slots[$];   // slots popped and not yet handed back
    int  n_sent    = 0;
    int  cycle_cnt = 0;
    bit  calm      = 1'b0;

    record_pool_free_list_queue #(.POOL_SLOTS(POOL_SLOTS)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic in_item_t mk(func_t f, logic [SLOT_W-1:0] idx);
        in_item_t it;
        it.func       = f;
        it.slot_index = idx;
        return it;
    endfunction

    // Mostly well-formed traffic: slots handed back are ones popped earlier.
    function automatic in_item_t pick_item(phase_t ph);
        in_item_t it;
        int       r;
        int       k;
        it.slot_index = SLOT_W'($urandom);
        r = $urandom_range(99);
        case (ph)
            PH_NOISE: begin
                it.func = func_t'($urandom_range(3));
                return it;
            end
            PH_ALLOC: it.func = (r < 85) ? FUNC_ALLOC : ((r < 93) ? FUNC_ENQUEUE : FUNC_DEQUEUE);
            PH_ENQ:   it.func = (r < 80) ? FUNC_ENQUEUE : FUNC_ALLOC;
            PH_DEQ:   it.func = (r < 85) ? FUNC_DEQUEUE : FUNC_RELEASE;
            PH_REL:   it.func = (r < 80) ? FUNC_RELEASE : FUNC_DEQUEUE;
            default:  it.func = func_t'($urandom_range(3));
        endcase
        if ((it.func == FUNC_RELEASE || it.func == FUNC_ENQUEUE) && held_slots.size() > 0) begin
            k = $urandom_range(held_slots.size() - 1);
            it.slot_index = held_slots[k];
            held_slots.delete(k);
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        out_item_t exp_r;
        while (!calm && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        exp_r = sb.note_input(it);
        if (exp_r.found)
            held_slots.push_back(exp_r.slot_out);
        n_sent++;
        calm = (n_sent >= 600 && n_sent < 800);
    endtask

    task automatic run_phase(phase_t ph, int len);
        for (int i = 0; i < len && n_sent < N_RANDOM; i++)
            send_item(pick_item(ph));
    endtask

    initial begin : result_sink
        bit rdy;
        forever begin
            rdy = calm || ($urandom_range(99) >= 35);
            m_ready <= rdy;
            @(posedge aclk);
            if (aresetn && m_valid && rdy)
                sb.check_result(m_item);
        end
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("** record_pool_free_list_queue: FAILED **");
        $finish;
    end

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty pops, extreme indexes, relinking slots already listed
        send_item(mk(FUNC_DEQUEUE, 8'h00));     // active list empty
        send_item(mk(FUNC_ALLOC,   8'hFF));     // index ignored
        send_item(mk(FUNC_ALLOC,   8'h00));
        send_item(mk(FUNC_ENQUEUE, 8'h00));
        send_item(mk(FUNC_ENQUEUE, 8'hFF));     // 255 still on free list
        send_item(mk(FUNC_DEQUEUE, 8'hAA));
        send_item(mk(FUNC_DEQUEUE, 8'h55));
        send_item(mk(FUNC_DEQUEUE, 8'hFF));     // empty again
        send_item(mk(FUNC_RELEASE, 8'h00));
        send_item(mk(FUNC_RELEASE, 8'h01));
        send_item(mk(FUNC_ENQUEUE, 8'h01));     // slot on free tail
        send_item(mk(FUNC_ENQUEUE, 8'h01));     // self loop on active list
        send_item(mk(FUNC_DEQUEUE, 8'h00));
        send_item(mk(FUNC_DEQUEUE, 8'h00));
        send_item(mk(FUNC_RELEASE, 8'hFF));
        send_item(mk(FUNC_RELEASE, 8'h80));
        send_item(mk(FUNC_ALLOC,   8'h7F));
        send_item(mk(FUNC_ALLOC,   8'h00));
        send_item(mk(FUNC_ENQUEUE, 8'h7F));
        send_item(mk(FUNC_DEQUEUE, 8'h00));

        // long allocate run first so the free list runs dry
        run_phase(PH_ALLOC, 320);
        while (n_sent < N_RANDOM) begin
            case ($urandom_range(9))
                0, 1:    run_phase(PH_ALLOC, $urandom_range(20, 120));
                2, 3:    run_phase(PH_ENQ,   $urandom_range(20, 120));
                4, 5:    run_phase(PH_DEQ,   $urandom_range(20, 120));
                6:       run_phase(PH_REL,   $urandom_range(20, 120));
                7, 8:    run_phase(PH_MIX,   $urandom_range(20, 80));
                default: run_phase(PH_NOISE, $urandom_range(10, 40));
            endcase
        end
        s_valid <= 1'b0;

        while (sb.owed_q.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("** record_pool_free_list_queue: PASSED **");
        else
            $display("** record_pool_free_list_queue: FAILED **");
        $finish;
    end

endmodule
